// ===== design/sorted_two_list_merge_unit_macros.svh =====
// Assertion macros used by the merge unit source.
`ifndef SORTED_TWO_LIST_MERGE_UNIT_MACROS_SVH
`define SORTED_TWO_LIST_MERGE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define STLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("merge unit check failed");
`define STLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("merge unit check failed");
`else
`define STLM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define STLM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/stlm_pkg.sv =====
package stlm_pkg;

  localparam int VALUE_W        = 32;
  localparam int CMD_W          = 2;
  localparam int LIST_DEPTH_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_APPEND_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MERGE         = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_MERGE = 2'b10
  } state_t;

endpackage

// ===== design/stlm_if.sv =====
interface stlm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [stlm_pkg::CMD_W-1:0]    command;
  logic signed [stlm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface stlm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [stlm_pkg::VALUE_W-1:0]  merged_value;
  logic                                 from_second;
  logic                                 entry_valid;
  logic                                 last_result;
  logic                                 overflow_seen;

  modport source (output valid, merged_value, from_second, entry_valid, last_result,
                  overflow_seen, input ready);
  modport sink   (input valid, merged_value, from_second, entry_valid, last_result,
                  overflow_seen, output ready);
endinterface

// ===== design/stlm_ram.sv =====
module stlm_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sorted_two_list_merge_unit.sv =====
// Append items are taken while the block is idle; ready stays high after an append.
// A merge item first fetches the list heads through the registered RAM reads, then emits one result per
// cycle through a single signed comparator while the output register drains.
// If both lists are empty, the merge emits one result with entry_valid low and last_result set.
// Reset (rst_n low, synchronous) empties both lists, clears the overflow flag
// and the output valid flag; list contents are not cleared.
`include "sorted_two_list_merge_unit_macros.svh"

module sorted_two_list_merge_unit #(
  parameter int LIST_DEPTH = stlm_pkg::LIST_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stlm_in_if.sink    in_ch,
  stlm_out_if.source out_ch
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int VW = stlm_pkg::VALUE_W;

  stlm_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] fc_r, fc_nxt, sc_r, sc_nxt;
  logic [CW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic          ovf_r, ovf_nxt;

  logic          we_a, we_b;
  logic signed [VW-1:0] rd_a, rd_b;

  logic          out_valid_r, out_valid_nxt;
  logic signed [VW-1:0] out_value_r;
  logic          out_second_r, out_entry_r, out_last_r, out_ovf_r;

  logic          accept, load, rem_a, rem_b, take_first, last_nxt;
  logic [CW-1:0] a_adv, b_adv;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == stlm_pkg::S_IDLE);
  assign load = (state_r == stlm_pkg::S_MERGE) && (!out_valid_r || out_ch.ready);

  assign rem_a = (a_r < fc_r);
  assign rem_b = (b_r < sc_r);
  assign take_first = rem_a && (!rem_b || (rd_a <= rd_b));
  assign a_adv = a_r + CW'(take_first);
  assign b_adv = b_r + CW'(rem_b && !take_first);
  assign last_nxt = (a_adv == fc_r) && (b_adv == sc_r);

  always_comb begin
    state_nxt = state_r;
    fc_nxt    = fc_r;
    sc_nxt    = sc_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    ovf_nxt   = ovf_r;
    we_a      = 1'b0;
    we_b      = 1'b0;
    unique case (state_r)
      stlm_pkg::S_IDLE: begin
        if (accept) begin
          case (in_ch.command)
            stlm_pkg::CMD_APPEND_FIRST: begin
              if (fc_r < CW'(LIST_DEPTH)) begin
                we_a   = 1'b1;
                fc_nxt = fc_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            stlm_pkg::CMD_APPEND_SECOND: begin
              if (sc_r < CW'(LIST_DEPTH)) begin
                we_b   = 1'b1;
                sc_nxt = sc_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            stlm_pkg::CMD_MERGE: begin
              a_nxt     = '0;
              b_nxt     = '0;
              state_nxt = stlm_pkg::S_MERGE;
            end
            default: begin
            end
          endcase
        end
      end
      stlm_pkg::S_MERGE: begin
        if (load) begin
          a_nxt = a_adv;
          b_nxt = b_adv;
          if (last_nxt) begin
            fc_nxt    = '0;
            sc_nxt    = '0;
            ovf_nxt   = 1'b0;
            state_nxt = stlm_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = stlm_pkg::S_IDLE;
      end
    endcase
  end

  stlm_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (fc_r[AW-1:0]),
    .wdata (in_ch.value),
    .raddr (a_nxt[AW-1:0]),
    .rdata (rd_a)
  );

  stlm_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (sc_r[AW-1:0]),
    .wdata (in_ch.value),
    .raddr (b_nxt[AW-1:0]),
    .rdata (rd_b)
  );

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stlm_pkg::S_IDLE;
      fc_r        <= '0;
      sc_r        <= '0;
      a_r         <= '0;
      b_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fc_r        <= fc_nxt;
      sc_r        <= sc_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ovf_r <= ovf_r;
      if (!rem_a && !rem_b) begin
        out_value_r  <= '0;
        out_second_r <= 1'b0;
        out_entry_r  <= 1'b0;
        out_last_r   <= 1'b1;
      end else begin
        out_value_r  <= take_first ? rd_a : rd_b;
        out_second_r <= !take_first;
        out_entry_r  <= 1'b1;
        out_last_r   <= last_nxt;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.merged_value  = out_value_r;
  assign out_ch.from_second   = out_second_r;
  assign out_ch.entry_valid   = out_entry_r;
  assign out_ch.last_result   = out_last_r;
  assign out_ch.overflow_seen = out_ovf_r;

  `STLM_ASSERT_NOW(a_ptr_in_range, clk, rst_n, state_r == stlm_pkg::S_MERGE, (a_r <= fc_r) && (b_r <= sc_r))
  `STLM_ASSERT_NOW(count_in_range, clk, rst_n, 1'b1, (fc_r <= CW'(LIST_DEPTH)) && (sc_r <= CW'(LIST_DEPTH)))
  `STLM_ASSERT_NEXT(clear_after_last, clk, rst_n, load && last_nxt, (state_r == stlm_pkg::S_IDLE) && (fc_r == '0) && (sc_r == '0) && !ovf_r)
  `STLM_ASSERT_NOW(empty_is_last, clk, rst_n, out_valid_r && !out_entry_r, out_last_r)

endmodule
